// ----- src/palette_quantize_alpha_dither_assert.svh -----
// Assertion macros shared by the palette quantizer modules.
`ifndef PALETTE_QUANTIZE_ALPHA_DITHER_ASSERT_SVH
`define PALETTE_QUANTIZE_ALPHA_DITHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PQAD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold after the delay dly, counted from the antecedent.
`define PQAD_ASSERT_DELAY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ----- src/pqad_pkg.sv -----
// Types, tables and constants of the palette quantizer.
`default_nettype none
package pqad_pkg;
	localparam int PAL_COUNT = 54;
	localparam int IDX_W = 6;
	localparam int DIST_W = 20;

	typedef struct packed {
		logic valid;
		logic kill;
	} pqad_ctl_t;

	typedef struct packed {
		logic [DIST_W-1:0] d;
		logic [IDX_W-1:0] idx;
	} pqad_cand_t;

	localparam logic [3:0] BAYER_RANK [16] = '{
		4'd0, 4'd8, 4'd2, 4'd10,
		4'd12, 4'd4, 4'd14, 4'd6,
		4'd3, 4'd11, 4'd1, 4'd9,
		4'd15, 4'd7, 4'd13, 4'd5
	};

	localparam logic [23:0] PALETTE [PAL_COUNT] = '{
		{8'd255, 8'd250, 8'd235}, {8'd255, 8'd232, 8'd170}, {8'd255, 8'd205, 8'd105},
		{8'd252, 8'd170, 8'd60}, {8'd245, 8'd130, 8'd35}, {8'd230, 8'd95, 8'd25},
		{8'd205, 8'd60, 8'd20}, {8'd160, 8'd32, 8'd24}, {8'd96, 8'd18, 8'd22},
		{8'd48, 8'd14, 8'd18}, {8'd38, 8'd26, 8'd22}, {8'd62, 8'd50, 8'd44},
		{8'd96, 8'd84, 8'd76}, {8'd140, 8'd128, 8'd118}, {8'd246, 8'd234, 8'd206},
		{8'd232, 8'd214, 8'd176}, {8'd210, 8'd188, 8'd142}, {8'd178, 8'd152, 8'd106},
		{8'd138, 8'd110, 8'd70}, {8'd96, 8'd70, 8'd40}, {8'd58, 8'd42, 8'd24},
		{8'd92, 8'd62, 8'd30}, {8'd176, 8'd40, 8'd44}, {8'd120, 8'd20, 8'd30},
		{8'd206, 8'd212, 8'd222}, {8'd168, 8'd178, 8'd194}, {8'd124, 8'd136, 8'd156},
		{8'd92, 8'd104, 8'd126}, {8'd64, 8'd74, 8'd94}, {8'd42, 8'd50, 8'd66},
		{8'd74, 8'd158, 8'd126}, {8'd128, 8'd96, 8'd162}, {8'd46, 8'd44, 8'd52},
		{8'd228, 8'd230, 8'd236}, {8'd214, 8'd118, 8'd122}, {8'd166, 8'd78, 8'd86},
		{8'd236, 8'd146, 8'd38}, {8'd226, 8'd216, 8'd196}, {8'd200, 8'd190, 8'd170},
		{8'd164, 8'd152, 8'd132}, {8'd140, 8'd128, 8'd112}, {8'd98, 8'd88, 8'd74},
		{8'd62, 8'd54, 8'd46}, {8'd232, 8'd168, 8'd60}, {8'd72, 8'd68, 8'd76},
		{8'd32, 8'd38, 8'd62}, {8'd52, 8'd62, 8'd98}, {8'd84, 8'd98, 8'd142},
		{8'd168, 8'd72, 8'd48}, {8'd206, 8'd104, 8'd66}, {8'd236, 8'd226, 8'd204},
		{8'd186, 8'd204, 8'd222}, {8'd132, 8'd156, 8'd184}, {8'd84, 8'd104, 8'd132}
	};
endpackage
`default_nettype wire

// ----- src/pqad_unpremul.sv -----
// Dither threshold test and un-premultiply by reciprocal multiplication.
`default_nettype none
module pqad_unpremul import pqad_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid_in,
	input wire logic [31:0] pixel,
	input wire logic [1:0] column_phase,
	input wire logic [1:0] row_phase,
	output pqad_ctl_t ctl_out,
	output logic [2:0][7:0] chan_out
);
	logic [24:0] recip_tab [256];
	logic [7:0] alpha;
	logic [7:0] thr;
	pqad_ctl_t ctl_s2, ctl_s3;
	logic [2:0][15:0] num_s2;
	logic [2:0][7:0] raw_s2;
	logic [24:0] recip_s2;
	logic full_s2;
	logic [2:0][7:0] chan_s3;
	logic [2:0][40:0] prod;

	assign recip_tab[0] = '0;
	for (genvar i = 1; i < 256; i++) begin : g_recip
		localparam int unsigned RecipVal = ((2 ** 24) + i - 1) / i;
		assign recip_tab[i] = RecipVal[24:0];
	end

	assign alpha = pixel[31:24];
	assign thr = {BAYER_RANK[{row_phase, column_phase}], 4'b1000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2.valid <= valid_in;
			ctl_s2.kill <= (alpha == 8'd0) || (alpha <= thr);
			ctl_s3 <= ctl_s2;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c] = 41'(num_s2[c]) * 41'(recip_s2);
		end
	end

	always_ff @(posedge clk) begin
		recip_s2 <= recip_tab[alpha];
		full_s2 <= (alpha == 8'hFF);
		for (int c = 0; c < 3; c++) begin
			raw_s2[c] <= pixel[8*c +: 8];
			num_s2[c] <= {pixel[8*c +: 8], 8'd0} - {8'd0, pixel[8*c +: 8]};
			if (full_s2) begin
				chan_s3[c] <= raw_s2[c];
			end else if (prod[c][40:24] > 17'd255) begin
				chan_s3[c] <= 8'hFF;
			end else begin
				chan_s3[c] <= prod[c][31:24];
			end
		end
	end

	assign ctl_out = ctl_s3;
	assign chan_out = chan_s3;
endmodule
`default_nettype wire

// ----- src/pqad_dist.sv -----
// Level truncation, expansion and weighted distance to every palette entry.
`default_nettype none
module pqad_dist import pqad_pkg::*; #(
	parameter int INDEX_BITS = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire pqad_ctl_t ctl_in,
	input wire logic [2:0][7:0] chan_in,
	output pqad_ctl_t ctl_out,
	output logic [PAL_COUNT-1:0][DIST_W-1:0] dist_out
);
	localparam int Levels = 1 << INDEX_BITS;
	localparam int LevelTop = Levels - 1;

	logic [7:0] exp_tab [Levels];
	pqad_ctl_t ctl_s4, ctl_s5;
	logic [2:0][7:0] exp_s4;
	logic [PAL_COUNT-1:0][DIST_W-1:0] dist_s5;
	logic [PAL_COUNT-1:0][DIST_W+1:0] dist_sum;

	for (genvar i = 0; i < Levels; i++) begin : g_exp
		localparam int unsigned ExpVal = (i * 255) / LevelTop;
		assign exp_tab[i] = ExpVal[7:0];
	end

	always_comb begin
		logic signed [9:0] dr, dg, db;
		logic signed [19:0] qr, qg, qb;
		logic [19:0] sr, sg, sb;
		for (int p = 0; p < PAL_COUNT; p++) begin
			dr = $signed({2'b00, exp_s4[2]}) - $signed({2'b00, PALETTE[p][23:16]});
			dg = $signed({2'b00, exp_s4[1]}) - $signed({2'b00, PALETTE[p][15:8]});
			db = $signed({2'b00, exp_s4[0]}) - $signed({2'b00, PALETTE[p][7:0]});
			qr = dr * dr;
			qg = dg * dg;
			qb = db * db;
			sr = $unsigned(qr);
			sg = $unsigned(qg);
			sb = $unsigned(qb);
			dist_sum[p] = 22'(sr) * 22'd3 + 22'(sg) * 22'd6 + 22'(sb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4 <= ctl_in;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			exp_s4[c] <= exp_tab[chan_in[c][7 -: INDEX_BITS]];
		end
		for (int p = 0; p < PAL_COUNT; p++) begin
			dist_s5[p] <= dist_sum[p][DIST_W-1:0];
		end
	end

	assign ctl_out = ctl_s5;
	assign dist_out = dist_s5;
endmodule
`default_nettype wire

// ----- src/pqad_argmin.sv -----
// Registered minimum tree over the palette distances, ties to the lower index.
`default_nettype none
module pqad_argmin import pqad_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire pqad_ctl_t ctl_in,
	input wire logic [PAL_COUNT-1:0][DIST_W-1:0] dist_in,
	output pqad_ctl_t ctl_out,
	output logic [IDX_W-1:0] idx_out
);
	`include "palette_quantize_alpha_dither_assert.svh"

	localparam int Leaves = 1 << IDX_W;

	pqad_ctl_t ctl_s6, ctl_s7, ctl_s8;
	pqad_cand_t leaf [Leaves];
	pqad_cand_t l1 [32];
	pqad_cand_t l2_s6 [16];
	pqad_cand_t l3 [8];
	pqad_cand_t l4_s7 [4];
	pqad_cand_t l5 [2];
	pqad_cand_t l6_s8;

	function automatic pqad_cand_t pick(pqad_cand_t lo, pqad_cand_t hi);
		return (hi.d < lo.d) ? hi : lo;
	endfunction

	always_comb begin
		for (int i = 0; i < PAL_COUNT; i++) begin
			leaf[i].idx = IDX_W'(i);
			leaf[i].d = dist_in[i];
		end
		for (int i = PAL_COUNT; i < Leaves; i++) begin
			leaf[i].idx = IDX_W'(i);
			leaf[i].d = '1;
		end
		for (int i = 0; i < 32; i++) begin
			l1[i] = pick(leaf[2*i], leaf[2*i+1]);
		end
		for (int i = 0; i < 8; i++) begin
			l3[i] = pick(l2_s6[2*i], l2_s6[2*i+1]);
		end
		for (int i = 0; i < 2; i++) begin
			l5[i] = pick(l4_s7[2*i], l4_s7[2*i+1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else begin
			ctl_s6 <= ctl_in;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 16; i++) begin
			l2_s6[i] <= pick(l1[2*i], l1[2*i+1]);
		end
		for (int i = 0; i < 4; i++) begin
			l4_s7[i] <= pick(l3[2*i], l3[2*i+1]);
		end
		l6_s8 <= pick(l5[0], l5[1]);
	end

	assign ctl_out = ctl_s8;
	assign idx_out = l6_s8.idx;

	`PQAD_ASSERT_IMP(a_idx_range, ctl_s8.valid && !ctl_s8.kill,
		l6_s8.idx < IDX_W'(PAL_COUNT), "palette index out of range")
endmodule
`default_nettype wire

// ----- src/palette_quantize_alpha_dither.sv -----
// Top level of the ordered-dither palette quantizer.
//
// Channel   Signals                               Direction
// request   start, busy, pixel_in, column_phase,  in
//           row_phase
// result    done, pixel_out                       out
//
// A request is taken in every cycle; busy is always low.
// Each result appears on done and pixel_out once its request has passed through all stages.
// The nine stages are the input register, two for the reciprocal multiply,
// two for the distances and three for the minimum tree, and the output register.
// Reset clears the stage valid bits only; no results are pending after reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module palette_quantize_alpha_dither import pqad_pkg::*; #(
	parameter int INDEX_BITS = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [31:0] pixel_in,
	input wire logic [1:0] column_phase,
	input wire logic [1:0] row_phase,
	output logic done,
	output logic [31:0] pixel_out
);
	`include "palette_quantize_alpha_dither_assert.svh"

	logic valid_s1;
	logic [31:0] pixel_s1;
	logic [1:0] col_s1, row_s1;
	pqad_ctl_t up_ctl, dist_ctl, min_ctl;
	logic [2:0][7:0] chan;
	logic [PAL_COUNT-1:0][DIST_W-1:0] dist_bus;
	logic [IDX_W-1:0] idx;
	logic done_s9;
	logic [31:0] pixel_s9;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s9 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s9 <= min_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		pixel_s1 <= pixel_in;
		col_s1 <= column_phase;
		row_s1 <= row_phase;
		if (min_ctl.kill || (idx >= IDX_W'(PAL_COUNT))) begin
			pixel_s9 <= '0;
		end else begin
			pixel_s9 <= {8'hFF, PALETTE[idx]};
		end
	end

	pqad_unpremul u_unpremul (
		.clk(clk),
		.arst_n(arst_n),
		.valid_in(valid_s1),
		.pixel(pixel_s1),
		.column_phase(col_s1),
		.row_phase(row_s1),
		.ctl_out(up_ctl),
		.chan_out(chan)
	);

	pqad_dist #(.INDEX_BITS(INDEX_BITS)) u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(up_ctl),
		.chan_in(chan),
		.ctl_out(dist_ctl),
		.dist_out(dist_bus)
	);

	pqad_argmin u_argmin (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(dist_ctl),
		.dist_in(dist_bus),
		.ctl_out(min_ctl),
		.idx_out(idx)
	);

	assign done = done_s9;
	assign pixel_out = pixel_s9;

	`PQAD_ASSERT_DELAY(a_latency, start && !busy, 9, done, "result missing after request")
	`PQAD_ASSERT_DELAY(a_zero_alpha, start && !busy && (pixel_in[31:24] == 8'd0), 9,
		pixel_out == 32'd0, "transparent request gave a nonzero pixel")
	`PQAD_ASSERT_IMP(a_opaque, done && (pixel_out != 32'd0), pixel_out[31:24] == 8'hFF,
		"visible result is not opaque")
endmodule
`default_nettype wire
